FILE: hdl/pal_pkg.sv
`default_nettype none
package pal_pkg;

  localparam int DATA_W    = 32;
  localparam int CNT_W     = 5;
  localparam int POS_W     = 4;
  localparam int OP_W      = 3;
  localparam int ST_W      = 2;
  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 40;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_READ_AT   = 3'd6,
    OP_NOP       = 3'd7
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_OVER   = 2'd1,
    ST_UNDER  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // shift command broadcast to every cell
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [CNT_W-1:0]  at;
    logic [DATA_W-1:0] value;
  } cmd_t;

endpackage
`default_nettype wire

FILE: hdl/pal_cell.sv
`default_nettype none
module pal_cell #(
  parameter int IDX = 0
) (
  input  wire logic                        clk_i,
  input  wire pal_pkg::cmd_t               cmd_i,
  input  wire logic [pal_pkg::DATA_W-1:0]  left_i,
  input  wire logic [pal_pkg::DATA_W-1:0]  right_i,
  output logic      [pal_pkg::DATA_W-1:0]  data_o
);

  logic [pal_pkg::DATA_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (32'(cmd_i.at) == IDX) begin
        data_d = cmd_i.value;
      end else if (32'(cmd_i.at) < IDX) begin
        data_d = left_i;
      end
    end else if (cmd_i.del && (32'(cmd_i.at) <= IDX)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

FILE: hdl/positional_array_list.sv
// Ordered list of signed 32-bit words held in a row of DEPTH cells, one entry per cell.
// Each stream word is one command (insert/delete at front, back or position, or read
// at position) and gives exactly one result word with status, the entry count after
// the command and the read value (zero unless a read succeeds). One command is taken
// every cycle while the output register is empty or being drained: every cell compares
// its own index with the command's index and shifts from its neighbor in that same
// cycle, and the result sits in that single register in the cycle after acceptance. The
// capacity register (address 0) limits the list to min(capacity, DEPTH) entries; the user
// must write it only while no command is in flight, which the block does not enforce.
`default_nettype none
module positional_array_list #(
  parameter int DEPTH = pal_pkg::DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // opcode[2:0], value[34:3], position[38:35], zero pad
  input  wire logic [pal_pkg::WORD_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // status[1:0], count[6:2], read_value[38:7], zero pad
  output logic      [pal_pkg::WORD_W-1:0]    m_axis_tdata,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pal_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [pal_pkg::PDATA_W-1:0]   pwdata,
  output logic      [pal_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);

  localparam int DW = pal_pkg::DATA_W;
  localparam int CW = pal_pkg::CNT_W;

  logic [CW-1:0]             cap_q;
  logic [CW-1:0]             count_q, count_d;
  logic                      m_valid_q;
  logic [pal_pkg::ST_W-1:0]  status_q;
  logic [CW-1:0]             rcount_q;
  logic [DW-1:0]             rdata_q;

  logic [pal_pkg::OP_W-1:0]  in_op;
  logic [DW-1:0]             in_value;
  logic [pal_pkg::POS_W-1:0] in_pos;
  logic                      accept;
  logic                      full, empty, pos_bad;
  pal_pkg::status_e          status_d;
  logic [DW-1:0]             rdata_d;
  logic [DW-1:0]             pos_data;
  pal_pkg::cmd_t             cmd;
  logic [DW-1:0]             cell_data [DEPTH];

  assign in_op    = s_axis_tdata[2:0];
  assign in_value = s_axis_tdata[34:3];
  assign in_pos   = s_axis_tdata[38:35];

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // config port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : {{(pal_pkg::PDATA_W-CW){1'b0}}, cap_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= pal_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      cap_q <= pwdata[CW-1:0];
    end
  end

  assign full    = (32'(count_q) >= DEPTH) || (count_q >= cap_q);
  assign empty   = (count_q == '0);
  assign pos_bad = ({1'b0, in_pos} >= count_q);

  always_comb begin
    pos_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (32'(in_pos) == i) begin
        pos_data = cell_data[i];
      end
    end
  end

  // command decode
  always_comb begin
    status_d  = pal_pkg::ST_OK;
    rdata_d   = '0;
    count_d   = count_q;
    cmd.ins   = 1'b0;
    cmd.del   = 1'b0;
    cmd.at    = '0;
    cmd.value = in_value;
    case (pal_pkg::op_e'(in_op))
      pal_pkg::OP_INS_FRONT: begin
        if (full) begin
          status_d = pal_pkg::ST_OVER;
        end else begin
          cmd.ins = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      pal_pkg::OP_INS_BACK: begin
        if (full) begin
          status_d = pal_pkg::ST_OVER;
        end else begin
          cmd.ins = 1'b1;
          cmd.at  = count_q;
          count_d = count_q + CW'(1);
        end
      end
      pal_pkg::OP_INS_AT: begin
        if (full) begin
          status_d = pal_pkg::ST_OVER;
        end else if (pos_bad) begin
          status_d = pal_pkg::ST_BADPOS;
        end else begin
          cmd.ins = 1'b1;
          cmd.at  = {1'b0, in_pos};
          count_d = count_q + CW'(1);
        end
      end
      pal_pkg::OP_DEL_FRONT: begin
        if (empty) begin
          status_d = pal_pkg::ST_UNDER;
        end else begin
          cmd.del = 1'b1;
          count_d = count_q - CW'(1);
        end
      end
      pal_pkg::OP_DEL_BACK: begin
        if (empty) begin
          status_d = pal_pkg::ST_UNDER;
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      pal_pkg::OP_DEL_AT: begin
        if (empty) begin
          status_d = pal_pkg::ST_UNDER;
        end else if (pos_bad) begin
          status_d = pal_pkg::ST_BADPOS;
        end else begin
          cmd.del = 1'b1;
          cmd.at  = {1'b0, in_pos};
          count_d = count_q - CW'(1);
        end
      end
      pal_pkg::OP_READ_AT: begin
        if (empty) begin
          status_d = pal_pkg::ST_UNDER;
        end else if (pos_bad) begin
          status_d = pal_pkg::ST_BADPOS;
        end else begin
          rdata_d = pos_data;
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      cmd.ins = 1'b0;
      cmd.del = 1'b0;
    end
  end

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = cell_data[i+1];
    end
    pal_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q   <= count_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rcount_q <= count_d;
      rdata_q  <= rdata_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(pal_pkg::WORD_W-DW-CW-pal_pkg::ST_W){1'b0}},
                          rdata_q, rcount_q, status_q};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= DEPTH)
    else $error("entry count above depth");

  a_result_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (rcount_q == count_q))
    else $error("result count differs from list count");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd.ins) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow list");

  a_fail_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (status_d != pal_pkg::ST_OK)) |=> $stable(count_q))
    else $error("failed command changed count");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while result stalled");
`endif

endmodule
`default_nettype wire
